### src/fwr_pkg.sv
package fwr_pkg;

	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int SECOND = (DEPTH > 1) ? 1 : 0;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} stat_t;

	typedef struct packed {
		logic latch;
		logic search;
		logic apply;
		logic list_start;
		logic list_emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic fill_zero;
		logic list_last;
		logic out_free;
	} dp_stat_t;

endpackage

### src/fwr_ctrl.sv
module fwr_ctrl import fwr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t dp_stat,
	output cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_APPLY = 4'b0100,
		S_LIST  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				case (dp_stat.op)
					OP_REMOVE: begin
						cmd.search = 1'b1;
						state_d    = S_APPLY;
					end
					OP_LIST: begin
						if (dp_stat.fill_zero) begin
							if (dp_stat.out_free) begin
								cmd.apply = 1'b1;
								state_d   = S_IDLE;
							end
						end else begin
							cmd.list_start = 1'b1;
							state_d        = S_LIST;
						end
					end
					default: begin
						if (dp_stat.out_free) begin
							cmd.apply = 1'b1;
							state_d   = S_IDLE;
						end
					end
				endcase
			end
			S_APPLY: begin
				if (dp_stat.out_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_LIST: begin
				if (dp_stat.out_free) begin
					cmd.list_emit = 1'b1;
					if (dp_stat.list_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### src/fwr_datapath.sv
module fwr_datapath import fwr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output dp_stat_t                 dp_stat,
	input  logic [1:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] item,
	output logic [5:0]               count,
	output logic [1:0]               status,
	output logic                     last
);

	op_t                      op_q;
	logic [DATA_W-1:0]        value_q;
	logic [DATA_W-1:0]        ent_q [DEPTH];
	logic [CNT_W-1:0]         fill_q;
	logic [DEPTH-1:0]         match_q;
	logic                     found_q;
	logic [IDX_W-1:0]         idx_q;

	logic [DATA_W-1:0]        item_q;
	logic [CNT_W-1:0]         count_q;
	stat_t                    status_q;
	logic                     last_q;
	logic                     out_valid_q;

	logic [DEPTH-1:0]         eq;
	logic [DEPTH-1:0]         ge_mask;
	logic                     empty;
	logic                     full;
	logic                     shift_en;
	logic                     wr_en;
	logic                     load;
	logic                     out_free;
	logic [DATA_W-1:0]        res_item;
	logic [CNT_W-1:0]         res_count;
	stat_t                    res_status;
	logic                     res_last;
	logic [CNT_W-1:0]         fill_d;
	logic [DATA_W-1:0]        head_after_shift;

	assign empty    = (fill_q == '0);
	assign full     = (fill_q == CNT_W'(DEPTH));
	assign out_free = !out_valid_q || !out_stall;
	assign load     = cmd.apply || cmd.list_emit;

	assign dp_stat.op        = op_q;
	assign dp_stat.fill_zero = empty;
	assign dp_stat.list_last = ((CNT_W'(idx_q) + 1'b1) == fill_q);
	assign dp_stat.out_free  = out_free;

	// Compare every held slot at once; only slots below the fill count take part.
	always_comb begin
		for (int i = 0; i < DEPTH; i++)
			eq[i] = (ent_q[i] == value_q) && (CNT_W'(i) < fill_q);
	end

	// A pop closes the gap from slot zero, a remove from the first matching slot.
	assign ge_mask  = (op_q == OP_POP) ? '1 : ~(match_q - 1'b1);
	assign shift_en = cmd.apply && !empty &&
		((op_q == OP_POP) || (op_q == OP_REMOVE && found_q));
	assign wr_en    = cmd.apply && (op_q == OP_PUSH) && !full;
	assign head_after_shift = (fill_q > CNT_W'(1)) ? ent_q[SECOND] : '0;

	always_comb begin
		res_item   = ent_q[0];
		res_count  = fill_q;
		res_status = STAT_OK;
		res_last   = 1'b1;
		fill_d     = fill_q;
		if (cmd.list_emit) begin
			res_item = ent_q[idx_q];
			res_last = dp_stat.list_last;
		end else if (empty && op_q != OP_PUSH) begin
			res_item   = '0;
			res_status = STAT_EMPTY;
		end else begin
			case (op_q)
				OP_PUSH: begin
					if (full) begin
						res_status = STAT_FULL;
					end else begin
						fill_d    = fill_q + 1'b1;
						res_count = fill_d;
						if (empty)
							res_item = value_q;
					end
				end
				OP_POP: begin
					fill_d    = fill_q - 1'b1;
					res_count = fill_d;
					res_item  = head_after_shift;
				end
				OP_REMOVE: begin
					if (!found_q) begin
						res_status = STAT_NOTFOUND;
					end else begin
						fill_d    = fill_q - 1'b1;
						res_count = fill_d;
						if (match_q[0])
							res_item = head_after_shift;
					end
				end
				default: res_status = STAT_OK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			value_q <= value;
		end
		if (cmd.search) begin
			match_q <= eq & (~eq + 1'b1);
			found_q <= |eq;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (shift_en && ge_mask[i])
				ent_q[i] <= ent_q[(i + 1 < DEPTH) ? i + 1 : i];
			else if (wr_en && fill_q == CNT_W'(i))
				ent_q[i] <= value_q;
		end
		if (load) begin
			item_q   <= res_item;
			count_q  <= res_count;
			status_q <= res_status;
			last_q   <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_PUSH;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch)
				op_q <= op_t'(op);
			if (cmd.apply)
				fill_q <= fill_d;
			if (cmd.list_start)
				idx_q <= '0;
			else if (cmd.list_emit)
				idx_q <= idx_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_free)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign item      = item_q;
	assign count     = 6'(count_q);
	assign status    = status_q;
	assign last      = last_q;

endmodule

### src/fifo_with_remove_by_value_core.sv
// Ordered queue of up to 32 signed words with push, pop, remove-first-match
// and list. Push and pop are accepted and then applied; remove is accepted,
// then runs the parallel compare over all slots, then closes the gap. A list
// is accepted and started, then emits one beat per held entry per cycle while
// the output is not stalled, head first, with last on the final beat. An
// empty queue answers every operation but push with item 0, count 0 and the
// empty status. The result beat sits in an output register, so a waiting
// result does not stall the work on the following operation until its own
// result is due.
module fifo_with_remove_by_value_core import fwr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] item,
	output logic [5:0]               count,
	output logic [1:0]               status,
	output logic                     last
);

	cmd_t     cmd;
	dp_stat_t dp_stat;

	fwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.dp_stat  (dp_stat),
		.cmd      (cmd)
	);

	fwr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.dp_stat   (dp_stat),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.item      (item),
		.count     (count),
		.status    (status),
		.last      (last)
	);

endmodule
